// ===== src/bpm_pkg.sv =====
// Shared types and constants for the binary pattern match counter.
// Used by the top level, the front end, the scan engine and the bench; depends on nothing.
package bpm_pkg;

    localparam int IMAGE_SIDE_DEF = 8;
    localparam int PIDX_W         = 6;
    localparam int SIDE_W         = 4;
    localparam int BITS_W         = 64;
    localparam int COUNT_W        = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BITS = 2'd1;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd1;

    // One count request: the pattern in force when the last pixel came in.
    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic [BITS_W-1:0] bits;
    } job_t;

endpackage

// ===== src/binary_pattern_match_counter.sv =====
// Top level of the binary pattern match counter: config registers, front, queue, back, RAM.
// Depends on bpm_pkg, bpm_ram, bpm_queue, bpm_front and bpm_back.
//
// The block takes a square binary image of IMAGE_SIDE x IMAGE_SIDE pixels, one pixel per
// item in raster order, at one item per cycle, and writes each pixel straight into a row
// store. The item marked last_pixel ends the image: its pixel is stored, a count job is
// queued, and the input stalls until the count is finished. The scan engine reads one image
// row per cycle from the single read port of the row store and tests every column offset of
// that row at once, so a count with pattern side s takes (IMAGE_SIDE - s + 1) * s row
// reads. The job passes through the queue before the reads; after them the drain state
// registers the result, or the hold state keeps it until the output is free. A pattern
// side of zero or larger than the image gives a count of zero with no row reads.
// Input resumes as soon as the result sits in the output register, even while it is still
// stalled there. The pattern is written through the configuration port:
// register 0 is the side (low four bits of the data), register 1 the 64 pattern bits,
// row-major with bit row * side + column; other indexes are ignored. Write it only while the
// block is idle. The store keeps its contents between images; a count over positions never
// written since reset returns an undefined value.
module binary_pattern_match_counter #(
    parameter int IMAGE_SIDE = bpm_pkg::IMAGE_SIDE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              pixel,
    input  logic                              last_pixel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bpm_pkg::COUNT_W-1:0]       match_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpm_pkg::BITS_W-1:0]        cfg_data
);

    localparam int ROW_W = (IMAGE_SIDE > 1) ? $clog2(IMAGE_SIDE) : 1;

    logic [bpm_pkg::SIDE_W-1:0] side_reg, side_next;
    logic [bpm_pkg::BITS_W-1:0] bits_reg, bits_next;
    logic                       cfg_write;

    logic                  wr_en;
    logic [ROW_W-1:0]      wr_addr;
    logic [IMAGE_SIDE-1:0] wr_mask, wr_data;
    logic                  rd_en;
    logic [ROW_W-1:0]      rd_addr;
    logic [IMAGE_SIDE-1:0] rd_data;

    logic                  q_push, q_full, q_pop, q_valid;
    bpm_pkg::job_t         q_in, q_out;
    logic                  back_busy;
    logic                  front_busy;

    // Configuration: always ready, decode the index, ignore unknown ones.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        side_next = side_reg;
        bits_next = bits_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                bpm_pkg::REG_PATTERN_SIDE: side_next = cfg_data[bpm_pkg::SIDE_W-1:0];
                bpm_pkg::REG_PATTERN_BITS: bits_next = cfg_data;
                default:                   side_next = side_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= bpm_pkg::SIDE_RESET;
            bits_reg <= '0;
        end
        else
        begin
            side_reg <= side_next;
            bits_reg <= bits_next;
        end
    end

    // Hold off pixels while a count is queued or the scan still owns the row store.
    assign front_busy = q_valid || q_full || back_busy;

    bpm_front #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .last_pixel   (last_pixel),
        .busy         (front_busy),
        .pattern_side (side_reg),
        .pattern_bits (bits_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_mask      (wr_mask),
        .wr_data      (wr_data),
        .job_push     (q_push),
        .job          (q_in)
    );

    bpm_queue #(
        .WIDTH ($bits(bpm_pkg::job_t)),
        .DEPTH (bpm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    bpm_ram #(
        .WIDTH (IMAGE_SIDE),
        .DEPTH (IMAGE_SIDE)
    ) u_image_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_mask (wr_mask),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bpm_back #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job         (q_out),
        .job_pop     (q_pop),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .busy        (back_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .match_count (match_count)
    );

    // The row store must never be written while the scan may read it.
    a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        back_busy |-> !wr_en)
        else $error("pixel written while scan engine busy");

    // The last pixel of an image closes the input until its count is done.
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_pixel) |=> in_stall)
        else $error("input not held off after last pixel");

    // A count job is never pushed into a full queue.
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("count job queue overflow");

    // No image holds more window positions than pixels.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (match_count <= bpm_pkg::COUNT_W'(IMAGE_SIDE * IMAGE_SIDE)))
        else $error("match count out of range");

endmodule

// ===== src/bpm_ram.sv =====
// Generic single-write, single-read RAM with per-bit write mask and registered read.
// Self-contained; used for the image row store.
module bpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_mask,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int b = 0; b < WIDTH; b++)
            begin
                if (wr_mask[b])
                begin
                    mem[wr_addr][b] <= wr_data[b];
                end
            end
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/bpm_queue.sv =====
// Short FIFO of count jobs between the pixel front end and the scan engine.
// Depends on nothing but its parameters.
module bpm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/bpm_front.sv =====
// Pixel front end: accepts items, writes pixels into the row store, queues a job on last.
// Depends on bpm_pkg.
module bpm_front #(
    parameter int IMAGE_SIDE = bpm_pkg::IMAGE_SIDE_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  logic                                          pixel,
    input  logic                                          last_pixel,
    input  logic                                          busy,
    input  logic [bpm_pkg::SIDE_W-1:0]                    pattern_side,
    input  logic [bpm_pkg::BITS_W-1:0]                    pattern_bits,
    output logic                                          wr_en,
    output logic [(IMAGE_SIDE > 1 ? $clog2(IMAGE_SIDE) : 1)-1:0] wr_addr,
    output logic [IMAGE_SIDE-1:0]                         wr_mask,
    output logic [IMAGE_SIDE-1:0]                         wr_data,
    output logic                                          job_push,
    output bpm_pkg::job_t                                 job
);

    localparam int ROW_W = (IMAGE_SIDE > 1) ? $clog2(IMAGE_SIDE) : 1;
    localparam logic [bpm_pkg::PIDX_W:0] AREA = (bpm_pkg::PIDX_W + 1)'(IMAGE_SIDE * IMAGE_SIDE);
    localparam logic [ROW_W-1:0] COL_LAST = ROW_W'(IMAGE_SIDE - 1);

    logic [bpm_pkg::PIDX_W-1:0] pidx_reg, pidx_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [ROW_W-1:0]           col_reg, col_next;
    logic                       accept;
    logic                       in_area;

    assign in_stall = busy;
    assign accept   = in_valid && !in_stall;
    // Addresses past the image area are never read: drop them.
    assign in_area  = ({1'b0, pidx_reg} < AREA);

    assign wr_en   = accept && in_area;
    assign wr_addr = row_reg;
    assign wr_mask = {{(IMAGE_SIDE - 1){1'b0}}, 1'b1} << col_reg;
    assign wr_data = {IMAGE_SIDE{pixel}};

    assign job_push  = accept && last_pixel;
    assign job.side  = pattern_side;
    assign job.bits  = pattern_bits;

    always_comb
    begin
        pidx_next = pidx_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (accept)
        begin
            if (last_pixel)
            begin
                pidx_next = '0;
                row_next  = '0;
                col_next  = '0;
            end
            else
            begin
                pidx_next = pidx_reg + 1'b1;
                if (pidx_next == '0)
                begin
                    row_next = '0;
                    col_next = '0;
                end
                else if (in_area)
                begin
                    if (col_reg == COL_LAST)
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pidx_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else
        begin
            pidx_reg <= pidx_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

endmodule

// ===== src/bpm_back.sv =====
// Scan engine: reads image rows, matches all window columns in parallel, sums matches.
// Depends on bpm_pkg; owns the result output register.
module bpm_back #(
    parameter int IMAGE_SIDE = bpm_pkg::IMAGE_SIDE_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          job_valid,
    input  bpm_pkg::job_t                                 job,
    output logic                                          job_pop,
    output logic                                          rd_en,
    output logic [(IMAGE_SIDE > 1 ? $clog2(IMAGE_SIDE) : 1)-1:0] rd_addr,
    input  logic [IMAGE_SIDE-1:0]                         rd_data,
    output logic                                          busy,
    output logic                                          out_valid,
    input  logic                                          out_stall,
    output logic [bpm_pkg::COUNT_W-1:0]                   match_count
);

    localparam int ROW_W  = (IMAGE_SIDE > 1) ? $clog2(IMAGE_SIDE) : 1;
    localparam int SIDE_W = bpm_pkg::SIDE_W;
    localparam int PIDX_W = bpm_pkg::PIDX_W;
    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(IMAGE_SIDE);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_HOLD  = 4'b1000
    } back_state_t;

    back_state_t                 state_reg, state_next;
    logic [SIDE_W-1:0]           side_reg, side_next;
    logic [bpm_pkg::BITS_W-1:0]  bits_reg, bits_next;
    logic [SIDE_W-1:0]           top_last_reg, top_last_next;
    logic [IMAGE_SIDE-1:0]       lane_mask_reg, lane_mask_next;
    logic [IMAGE_SIDE-1:0]       col_mask_reg, col_mask_next;
    logic [ROW_W-1:0]            top_reg, top_next;
    logic [ROW_W-1:0]            i_reg, i_next;
    logic                        p1_valid_reg, p1_valid_next;
    logic                        p1_first_reg, p1_first_next;
    logic                        p1_rowlast_reg, p1_rowlast_next;
    logic [IMAGE_SIDE-1:0]       p1_prow_reg, p1_prow_next;
    logic [IMAGE_SIDE-1:0]       match_vec_reg, match_vec_next;
    logic [bpm_pkg::COUNT_W-1:0] total_reg, total_next;
    logic                        res_valid_reg, res_valid_next;
    logic [bpm_pkg::COUNT_W-1:0] res_reg, res_next;

    logic                        out_free;
    logic                        i_last, top_last;
    logic [PIDX_W-1:0]           row_off;
    logic [bpm_pkg::BITS_W-1:0]  bits_shifted;
    logic [IMAGE_SIDE-1:0]       lane_ok, match_now, shifted;
    logic [SIDE_W-1:0]           lane_cnt;
    logic [bpm_pkg::COUNT_W-1:0] total_step;

    assign busy        = (state_reg != ST_IDLE);
    assign out_valid   = res_valid_reg;
    assign match_count = res_reg;
    assign out_free    = !res_valid_reg || !out_stall;

    assign i_last   = ({{(SIDE_W - ROW_W){1'b0}}, i_reg} == side_reg - 1'b1);
    assign top_last = ({{(SIDE_W - ROW_W){1'b0}}, top_reg} == top_last_reg);

    assign rd_en   = (state_reg == ST_ISSUE);
    assign rd_addr = top_reg + i_reg;

    // Pattern row i starts at bit i * side.
    assign row_off      = PIDX_W'(i_reg) * PIDX_W'(side_reg);
    assign bits_shifted = bits_reg >> row_off;

    // Compare the returned image row against the pattern row at every column offset.
    always_comb
    begin
        for (int c = 0; c < IMAGE_SIDE; c++)
        begin
            shifted    = rd_data >> c;
            lane_ok[c] = lane_mask_reg[c] && (((shifted ^ p1_prow_reg) & col_mask_reg) == '0);
        end
        match_now = p1_first_reg ? lane_ok : (match_vec_reg & lane_ok);
        lane_cnt  = '0;
        for (int c = 0; c < IMAGE_SIDE; c++)
        begin
            lane_cnt = lane_cnt + SIDE_W'(match_now[c]);
        end
        total_step = total_reg;
        if (p1_valid_reg && p1_rowlast_reg)
        begin
            total_step = total_reg + bpm_pkg::COUNT_W'(lane_cnt);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        side_next       = side_reg;
        bits_next       = bits_reg;
        top_last_next   = top_last_reg;
        lane_mask_next  = lane_mask_reg;
        col_mask_next   = col_mask_reg;
        top_next        = top_reg;
        i_next          = i_reg;
        p1_valid_next   = 1'b0;
        p1_first_next   = p1_first_reg;
        p1_rowlast_next = p1_rowlast_reg;
        p1_prow_next    = p1_prow_reg;
        match_vec_next  = p1_valid_reg ? match_now : match_vec_reg;
        total_next      = total_step;
        res_valid_next  = res_valid_reg && out_stall;
        res_next        = res_reg;
        job_pop         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop       = 1'b1;
                    side_next     = job.side;
                    bits_next     = job.bits;
                    top_last_next = SIDE_MAX - job.side;
                    top_next      = '0;
                    i_next        = '0;
                    total_next    = '0;
                    for (int c = 0; c < IMAGE_SIDE; c++)
                    begin
                        lane_mask_next[c] = (SIDE_W'(c) <= (SIDE_MAX - job.side));
                        col_mask_next[c]  = (SIDE_W'(c) < job.side);
                    end
                    // Empty or oversized pattern: no window fits, count is zero.
                    if (job.side == '0 || job.side > SIDE_MAX)
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                p1_valid_next   = 1'b1;
                p1_first_next   = (i_reg == '0);
                p1_rowlast_next = i_last;
                p1_prow_next    = bits_shifted[IMAGE_SIDE-1:0] & col_mask_reg;
                if (i_last)
                begin
                    i_next = '0;
                    if (top_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        top_next = top_reg + 1'b1;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = total_step;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = total_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_valid_reg  <= p1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg       <= side_next;
        bits_reg       <= bits_next;
        top_last_reg   <= top_last_next;
        lane_mask_reg  <= lane_mask_next;
        col_mask_reg   <= col_mask_next;
        top_reg        <= top_next;
        i_reg          <= i_next;
        p1_first_reg   <= p1_first_next;
        p1_rowlast_reg <= p1_rowlast_next;
        p1_prow_reg    <= p1_prow_next;
        match_vec_reg  <= match_vec_next;
        total_reg      <= total_next;
        res_reg        <= res_next;
    end

endmodule

// ===== sim/binary_pattern_match_counter_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for binary_pattern_match_counter: images go in pixel by pixel,
// each count is predicted by a window scan over a mirrored pixel store and compared.
// Depends on bpm_pkg and the binary_pattern_match_counter RTL.
module binary_pattern_match_counter_tb;

    localparam int IMG            = bpm_pkg::IMAGE_SIDE_DEF;
    localparam int STORE_DEPTH    = 64;
    localparam int SETTLE_CYCLES  = 40;
    localparam int ITEM_TARGET    = 400;
    localparam int ROUND_LIMIT    = 600;
    localparam int CYCLE_LIMIT    = 400000;

    // Indexes outside the register map; writes there must leave the pattern alone.
    localparam logic [bpm_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [bpm_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          pixel;
    logic                          last_pixel;
    logic                          out_valid;
    logic                          out_stall;
    logic [bpm_pkg::COUNT_W-1:0]   match_count;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [bpm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bpm_pkg::BITS_W-1:0]    cfg_data;

    // Mirror of the block: pixel store, write address and pattern registers.
    bit                            img_model [STORE_DEPTH];
    logic [bpm_pkg::PIDX_W-1:0]    img_ptr;
    logic [bpm_pkg::SIDE_W-1:0]    side_model;
    logic [bpm_pkg::BITS_W-1:0]    bits_model;

    logic [bpm_pkg::COUNT_W-1:0]   counts_due [$];
    int unsigned                   fail_count;
    int unsigned                   pixels_sent;
    int unsigned                   counts_seen;
    int unsigned                   cycle_count;

    // Idle stretches for each side: a quiet stretch draws no waits at all.
    bit                            in_quiet;
    int unsigned                   in_streak;
    bit                            out_quiet;
    int unsigned                   out_streak;

    binary_pattern_match_counter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .last_pixel  (last_pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .match_count (match_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Count every window position fully inside the image that equals the pattern.
    function automatic logic [bpm_pkg::COUNT_W-1:0] count_windows();
        int  s;
        int  span;
        int  total;
        bit  hit;
        s     = side_model;
        total = 0;
        if (s == 0 || s > IMG)
        begin
            return '0;
        end
        span = IMG - s + 1;
        for (int r = 0; r < span; r++)
        begin
            for (int c = 0; c < span; c++)
            begin
                hit = 1'b1;
                for (int i = 0; i < s; i++)
                begin
                    for (int j = 0; j < s; j++)
                    begin
                        if (img_model[(r + i) * IMG + c + j] != bits_model[(i * s + j) % 64])
                        begin
                            hit = 1'b0;
                        end
                    end
                end
                if (hit)
                begin
                    total++;
                end
            end
        end
        return total[bpm_pkg::COUNT_W-1:0];
    endfunction

    // Draw the wait before one item, or none at all during a quiet stretch.
    function automatic int unsigned pick_gap(inout bit quiet, inout int unsigned streak);
        if (streak == 0)
        begin
            quiet  = ($urandom_range(0, 2) == 0);
            streak = $urandom_range(4, 24);
        end
        streak--;
        if (quiet || $urandom_range(0, 1) == 0)
        begin
            return 0;
        end
        return $urandom_range(1, 17);
    endfunction

    // Store contents as they will stand once the given image has gone in.
    function automatic void project(input bit pixels[$], output bit proj[STORE_DEPTH]);
        int a;
        a = img_ptr;
        foreach (img_model[k])
        begin
            proj[k] = img_model[k];
        end
        foreach (pixels[k])
        begin
            proj[a] = pixels[k];
            a = (a + 1) % STORE_DEPTH;
        end
    endfunction

    // Pattern copied from one window of the store; bits past side squared stay random.
    function automatic logic [bpm_pkg::BITS_W-1:0] window_bits(input bit proj[STORE_DEPTH],
                                                               input int s, input int top,
                                                               input int left);
        logic [bpm_pkg::BITS_W-1:0] w;
        w = {$urandom, $urandom};
        for (int i = 0; i < s; i++)
        begin
            for (int j = 0; j < s; j++)
            begin
                w[i * s + j] = proj[(top + i) * IMG + left + j];
            end
        end
        return w;
    endfunction

    // Model update and result check; outputs are compared before a new count is queued.
    always @(posedge clk)
    begin : track
        logic [bpm_pkg::COUNT_W-1:0] want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (counts_due.size() == 0)
                begin
                    $error("match_count: no result expected, got %0d", match_count);
                    fail_count++;
                end
                else
                begin
                    want = counts_due.pop_front();
                    if (match_count !== want)
                    begin
                        $error("match_count: expected %0d, got %0d", want, match_count);
                        fail_count++;
                    end
                end
                counts_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bpm_pkg::REG_PATTERN_SIDE)
                begin
                    side_model = cfg_data[bpm_pkg::SIDE_W-1:0];
                end
                else if (cfg_index == bpm_pkg::REG_PATTERN_BITS)
                begin
                    bits_model = cfg_data;
                end
            end
            if (in_valid && !in_stall)
            begin
                img_model[img_ptr] = pixel;
                if (last_pixel)
                begin
                    img_ptr = '0;
                    counts_due.push_back(count_windows());
                end
                else
                begin
                    img_ptr = img_ptr + 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("binary_pattern_match_counter verification failed");
            $finish;
        end
    end

    // Result side: stall for a drawn number of cycles, then take one item.
    initial
    begin : result_sink
        int unsigned hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = pick_gap(out_quiet, out_streak);
            if (hold != 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
                out_stall = 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // Send one pixel; start and end at a falling edge. Valid stays high for the
    // next item unless a gap is drawn.
    task automatic send_pixel(input bit px, input bit last);
        int unsigned gap;
        gap = pick_gap(in_quiet, in_streak);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel      = px;
        last_pixel = last;
        in_valid   = 1'b1;
        do @(posedge clk); while (in_stall);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic send_image(input bit pixels[$]);
        foreach (pixels[k])
        begin
            send_pixel(pixels[k], k == pixels.size() - 1);
        end
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [bpm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpm_pkg::BITS_W-1:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Side goes in the low nibble; the rest of the data word is noise.
    task automatic write_side(input int s);
        logic [bpm_pkg::BITS_W-1:0] data;
        data = {$urandom, $urandom};
        data[bpm_pkg::SIDE_W-1:0] = s[bpm_pkg::SIDE_W-1:0];
        write_reg(bpm_pkg::REG_PATTERN_SIDE, data);
    endtask

    // Drain every pending count, then let the pipeline settle before touching registers.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (counts_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Reset pattern (side 1, all zero) over a blank image: every position matches.
    task automatic test_reset_pattern();
        bit pixels[$];
        repeat (STORE_DEPTH) pixels.push_back(1'b0);
        send_image(pixels);
    endtask

    // Spare indexes must be dropped: the count still runs on the reset pattern.
    task automatic test_unknown_index();
        bit pixels[$];
        wait_idle();
        write_reg(REG_SPARE_2, {$urandom, $urandom});
        write_reg(REG_SPARE_3, {$urandom, $urandom});
        pixels.push_back(1'b1);
        send_image(pixels);
    endtask

    // Full-image pattern, side zero, and sides past the image edge.
    task automatic test_side_limits();
        bit pixels[$];
        bit proj[STORE_DEPTH];
        wait_idle();
        pixels = '{1'b0, 1'b1};
        project(pixels, proj);
        write_side(IMG);
        write_reg(bpm_pkg::REG_PATTERN_BITS, window_bits(proj, IMG, 0, 0));
        send_image(pixels);
        wait_idle();
        write_side(0);
        pixels = '{1'b1};
        send_image(pixels);
        wait_idle();
        write_side(9);
        write_reg(bpm_pkg::REG_PATTERN_BITS, '1);
        send_image(pixels);
        wait_idle();
        write_side(15);
        send_image(pixels);
    endtask

    // Bits past side squared are all ones and must not spoil a real match.
    task automatic test_unused_bits();
        bit                         pixels[$];
        bit                         proj[STORE_DEPTH];
        logic [bpm_pkg::BITS_W-1:0] pat;
        wait_idle();
        repeat (5) pixels.push_back($urandom_range(0, 1));
        project(pixels, proj);
        pat = window_bits(proj, 3, $urandom_range(0, IMG - 3), $urandom_range(0, IMG - 3));
        pat[bpm_pkg::BITS_W-1:9] = '1;
        write_side(3);
        write_reg(bpm_pkg::REG_PATTERN_BITS, pat);
        send_image(pixels);
    endtask

    // Last pixel after only a few: the rest of the store keeps the older image.
    task automatic test_early_last();
        bit pixels[$];
        wait_idle();
        write_side(1);
        write_reg(bpm_pkg::REG_PATTERN_BITS, 64'd1);
        pixels = '{1'b1, 1'b1, 1'b0};
        send_image(pixels);
    endtask

    // More pixels than the store holds: the write address wraps to the start.
    task automatic test_pixel_wrap();
        bit pixels[$];
        bit proj[STORE_DEPTH];
        wait_idle();
        repeat (STORE_DEPTH + 1) pixels.push_back($urandom_range(0, 1));
        project(pixels, proj);
        write_side(2);
        write_reg(bpm_pkg::REG_PATTERN_BITS, window_bits(proj, 2, IMG - 2, IMG - 2));
        send_image(pixels);
    endtask

    // Mostly short image updates with patterns cut from the image so matches occur;
    // the rest are longer, full or wrapping images, random patterns and out-of-range sides.
    task automatic test_random_images();
        bit                         pixels[$];
        bit                         proj[STORE_DEPTH];
        int unsigned                rounds;
        int                         n;
        int                         s;
        int                         mode;
        int                         pick;
        bit                         solid;
        bit                         side_first;
        logic [bpm_pkg::BITS_W-1:0] pat;
        rounds = 0;
        while (pixels_sent < ITEM_TARGET && rounds < ROUND_LIMIT)
        begin
            rounds++;
            wait_idle();
            pixels.delete();

            pick = $urandom_range(0, 99);
            if (pick < 65)
                n = $urandom_range(1, 12);
            else if (pick < 88)
                n = $urandom_range(13, STORE_DEPTH - 1);
            else if (pick < 96)
                n = STORE_DEPTH;
            else
                n = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 16);

            // Density: even, sparse, dense or a solid fill.
            mode  = $urandom_range(0, 3);
            solid = $urandom_range(0, 1);
            repeat (n)
            begin
                case (mode)
                    0:       pixels.push_back($urandom_range(0, 1));
                    1:       pixels.push_back($urandom_range(0, 7) == 0);
                    2:       pixels.push_back($urandom_range(0, 7) != 0);
                    default: pixels.push_back(solid);
                endcase
            end
            project(pixels, proj);

            pick = $urandom_range(0, 19);
            if (pick == 0)
                s = 0;
            else if (pick == 1)
                s = $urandom_range(IMG + 1, 15);
            else
                s = $urandom_range(1, $urandom_range(1, IMG));
            if ($urandom_range(0, 4) == 0)
                s = side_model;

            if (s >= 1 && s <= IMG && $urandom_range(0, 9) < 7)
            begin
                pat = window_bits(proj, s, $urandom_range(0, IMG - s),
                                  $urandom_range(0, IMG - s));
                // Near miss: one pattern pixel flipped.
                if ($urandom_range(0, 4) == 0)
                    pat[$urandom_range(0, s * s - 1)] ^= 1'b1;
            end
            else
            begin
                pat = {$urandom, $urandom};
            end

            side_first = $urandom_range(0, 1);
            if (side_first && s != side_model)
                write_side(s);
            if ($urandom_range(0, 5) != 0)
                write_reg(bpm_pkg::REG_PATTERN_BITS, pat);
            if (!side_first && s != side_model)
                write_side(s);
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          {$urandom, $urandom});

            send_image(pixels);
        end
    endtask

    initial
    begin : run
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pixel       = 1'b0;
        last_pixel  = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = bpm_pkg::REG_PATTERN_SIDE;
        cfg_data    = '0;
        img_ptr     = '0;
        side_model  = bpm_pkg::SIDE_RESET;
        bits_model  = '0;
        fail_count  = 0;
        pixels_sent = 0;
        counts_seen = 0;
        cycle_count = 0;
        in_quiet    = 1'b0;
        in_streak   = 0;
        out_quiet   = 1'b0;
        out_streak  = 0;
        foreach (img_model[k])
        begin
            img_model[k] = 1'b0;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The first image fills the whole store, so no count ever reads an unwritten pixel.
        test_reset_pattern();
        test_unknown_index();
        test_side_limits();
        test_unused_bits();
        test_early_last();
        test_pixel_wrap();
        test_random_images();

        wait_idle();
        if (fail_count == 0 && counts_due.size() == 0)
        begin
            $display("binary_pattern_match_counter verification clean");
        end
        else
        begin
            $display("binary_pattern_match_counter verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/bpm_pkg.sv
src/bpm_ram.sv
src/bpm_queue.sv
src/bpm_front.sv
src/bpm_back.sv
src/binary_pattern_match_counter.sv
sim/binary_pattern_match_counter_tb.sv
